// ----- design/rct_pkg.sv -----
// Shared types, constants and helpers for the recurring compare timer.
// No dependencies; all other design files refer to it by scoped names.
package rct_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int CHAN_W       = 2;
   localparam int CMD_W        = 2;
   localparam int PERIOD_W     = 32;
   localparam int PDIV_W       = 29;
   localparam int TIME_W       = 64;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 80;

   localparam logic [PERIOD_W-1:0] DIV10_MUL   = 32'hCCCC_CCCD;
   localparam int                  DIV10_SHIFT = 35;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK    = 2'd0,
      CMD_START   = 2'd1,
      CMD_CANCEL  = 2'd2,
      CMD_RESCHED = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [CHAN_W-1:0]    channel;
      logic [PERIOD_W-1:0]  period;
      logic [PDIV_W-1:0]    period_div;
   } item_type;

   typedef struct packed {
      logic [NUM_CHANNELS-1:0] running_flags;
      logic                    missed;
      logic [NUM_CHANNELS-1:0] match_flags;
      logic [TIME_W-1:0]       time_now;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   // exact floor(x / 10) for any 32-bit x by reciprocal multiply
   function automatic logic [PDIV_W-1:0] div10(input logic [PERIOD_W-1:0] x);
      logic [2*PERIOD_W-1:0] prod;
      prod = (2*PERIOD_W)'(x) * (2*PERIOD_W)'(DIV10_MUL);
      return prod[DIV10_SHIFT +: PDIV_W];
   endfunction

endpackage

// ----- design/rct_in_stage.sv -----
// Input register of the recurring compare timer: takes request words and
// precomputes period/10. Depends on rct_pkg.
module rct_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rct_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [rct_pkg::CMD_W-1:0]      req_tuser,
   input  logic                          take,
   output logic                          item_valid,
   output rct_pkg::item_type             item
);

   logic              valid_ff, valid_in;
   rct_pkg::item_type item_ff, item_in;
   logic              accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in           = accept ? 1'b1 : (take ? 1'b0 : valid_ff);
      item_in.cmd        = rct_pkg::cmd_type'(req_tuser);
      item_in.channel    = req_tdata[rct_pkg::CHAN_W-1:0];
      item_in.period     = req_tdata[rct_pkg::CHAN_W +: rct_pkg::PERIOD_W];
      item_in.period_div = rct_pkg::div10(item_in.period);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- design/rct_core.sv -----
// Counter and compare channel state of the recurring compare timer. Depends
// on rct_pkg. Applies one command per cycle unless stalled, forms result.
module rct_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  rct_pkg::item_type    item,
   input  logic                 out_space,
   output logic                 fire,
   output rct_pkg::result_type  result
);

   localparam int N  = rct_pkg::NUM_CHANNELS;
   localparam int PW = rct_pkg::PERIOD_W;
   localparam int TW = rct_pkg::TIME_W;
   localparam int DW = rct_pkg::PDIV_W;

   logic [TW-1:0] counter_ff, counter_in;
   logic [N-1:0]  running_ff, running_in;
   logic [N-1:0]  match_ff, match_in;
   logic [PW-1:0] period_ff [N];
   logic [PW-1:0] period_in [N];
   logic [DW-1:0] pdiv_ff [N];
   logic [DW-1:0] pdiv_in [N];
   logic [TW-1:0] nf_ff [N];
   logic [TW-1:0] nf_in [N];
   logic [PW-1:0] cmp_ff [N];
   logic [PW-1:0] cmp_in [N];

   logic [rct_pkg::CHAN_W-1:0] ch;
   logic          per_given;
   logic [PW-1:0] per_eff;
   logic [DW-1:0] pdiv_eff;
   logic [TW-1:0] now_plus_per;
   logic [TW-1:0] nf_sum;
   logic [TW-1:0] threshold;
   logic          late;
   logic          missed;
   logic [N-1:0]  per_zero;

   assign fire      = item_valid && out_space;
   assign ch        = item.channel;
   assign per_given = item.period != '0;
   assign per_eff   = per_given ? item.period : period_ff[ch];
   assign pdiv_eff  = per_given ? item.period_div : pdiv_ff[ch];

   assign now_plus_per = counter_ff + TW'(per_eff);
   assign nf_sum       = nf_ff[ch] + TW'(per_eff);
   assign threshold    = counter_ff + TW'(pdiv_eff);
   assign late         = nf_sum < threshold;

   always_comb begin
      counter_in = counter_ff;
      running_in = running_ff;
      match_in   = match_ff;
      period_in  = period_ff;
      pdiv_in    = pdiv_ff;
      nf_in      = nf_ff;
      cmp_in     = cmp_ff;
      missed     = 1'b0;
      case (item.cmd)
         rct_pkg::CMD_TICK: begin
            counter_in = counter_ff + TW'(1);
            for (int c = 0; c < N; c++) begin
               if (cmp_ff[c] == counter_in[PW-1:0]) begin
                  match_in[c] = 1'b1;
               end
            end
         end
         rct_pkg::CMD_START: begin
            if (per_given) begin
               running_in[ch] = 1'b1;
               period_in[ch]  = item.period;
               pdiv_in[ch]    = item.period_div;
               nf_in[ch]      = now_plus_per;
               cmp_in[ch]     = now_plus_per[PW-1:0];
            end
         end
         rct_pkg::CMD_CANCEL: begin
            running_in[ch] = 1'b0;
            period_in[ch]  = '0;
            pdiv_in[ch]    = '0;
         end
         rct_pkg::CMD_RESCHED: begin
            if (running_ff[ch] && per_eff != '0) begin
               period_in[ch] = per_eff;
               pdiv_in[ch]   = pdiv_eff;
               missed        = late;
               nf_in[ch]     = late ? now_plus_per : nf_sum;
               cmp_in[ch]    = late ? now_plus_per[PW-1:0] : nf_sum[PW-1:0];
            end
            match_in[ch] = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         running_ff <= '0;
         match_ff   <= '0;
         for (int c = 0; c < N; c++) begin
            period_ff[c] <= '0;
            pdiv_ff[c]   <= '0;
            nf_ff[c]     <= '0;
            cmp_ff[c]    <= '0;
         end
      end else if (fire) begin
         counter_ff <= counter_in;
         running_ff <= running_in;
         match_ff   <= match_in;
         period_ff  <= period_in;
         pdiv_ff    <= pdiv_in;
         nf_ff      <= nf_in;
         cmp_ff     <= cmp_in;
      end
   end

   always_comb begin
      result.time_now      = counter_in;
      result.match_flags   = match_in;
      result.missed        = missed;
      result.running_flags = running_in;
      for (int c = 0; c < N; c++) begin
         per_zero[c] = period_ff[c] == '0;
      end
   end

   a_run_has_period: assert property (@(posedge clock) disable iff (reset)
      (running_ff & per_zero) == '0)
      else $error("armed channel holds a zero period");

   a_counter_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (fire && item.cmd != rct_pkg::CMD_TICK) |=> $stable(counter_ff))
      else $error("counter moved on a non-tick command");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(counter_ff) && $stable(running_ff) && $stable(match_ff)))
      else $error("state changed without a command");

   a_resched_acks: assert property (@(posedge clock) disable iff (reset)
      (fire && item.cmd == rct_pkg::CMD_RESCHED) |=> !match_ff[$past(ch)])
      else $error("reschedule left match flag set");

   a_missed_only_resched: assert property (@(posedge clock) disable iff (reset)
      (fire && result.missed) |-> item.cmd == rct_pkg::CMD_RESCHED)
      else $error("miss flagged outside reschedule");

endmodule

// ----- design/rct_out_stage.sv -----
// Result register of the recurring compare timer: holds a response word
// until the consumer takes it. Depends on rct_pkg.
module rct_out_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  rct_pkg::result_type            result,
   output logic                           out_space,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rct_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic                           valid_ff, valid_in;
   logic [rct_pkg::RSP_DATA_W-1:0] data_ff;

   assign out_space = !valid_ff || rsp_tready;
   assign valid_in  = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= rct_pkg::RSP_DATA_W'(result);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ----- design/recurring_compare_timer.sv -----
// Top level of the recurring compare timer: input register, channel core and
// result register. Depends on rct_pkg, rct_in_stage, rct_core, rct_out_stage.
//
//   channel | direction | tdata (low bit up)                         | tuser
//   req_    | in        | channel[1:0], period_us[33:2], pad[39:34]  | cmd[1:0]
//   rsp_    | out       | time_now[63:0], match_flags[67:64],        | -
//           |           | missed[68], running_flags[72:69], pad      |
//
// A request passes the input register (period/10 multiply), then the channel
// core (64-bit adds and compare), whose result is held in the result register.
// One word per cycle is sustained while rsp_tready stays high. Synchronous
// reset clears the counter and all channel state. A stalled response holds its
// word and stops the input register, which in turn drops req_tready.
module recurring_compare_timer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rct_pkg::REQ_DATA_W-1:0] req_tdata,  // channel, period_us
   input  logic [rct_pkg::CMD_W-1:0]      req_tuser,  // cmd
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rct_pkg::RSP_DATA_W-1:0] rsp_tdata   // time_now, match_flags, missed, running_flags
);

   logic                item_valid;
   rct_pkg::item_type   item;
   logic                fire;
   logic                out_space;
   rct_pkg::result_type result;

   rct_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   rct_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_space  (out_space),
      .fire       (fire),
      .result     (result)
   );

   rct_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result     (result),
      .out_space  (out_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
